### design/ilb_pkg.sv
// Package for the indexed list buffer: request and result types, request
// and status codes, and the control word that steers each list cell.
// No dependencies.
`default_nettype none

package ilb_pkg;

  // Request codes
  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_TAIL = 3'd2,
    REQ_INS_POS  = 3'd3,
    REQ_DEL_POS  = 3'd4
  } req_code_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic signed [31:0] READ_MISS = -32'sd1;

  // One request
  typedef struct packed {
    logic [2:0]         req_type;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  // One result
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         list_length;
  } rsp_t;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/indexed_list_buffer_core.sv
// Indexed list buffer top level: request decode, length register, a row of
// ilb_cell instances and the result register. Uses ilb_pkg and ilb_cell.
//
//  channel | ports                 | transfer
//  --------+-----------------------+-----------------------------------
//  request | start, busy, req      | start high and busy low at the edge
//  result  | done, rsp             | done high for one cycle, no stall
//
// The result appears on rsp with done in the cycle after its transfer, so a
// new request may follow in every cycle.
// Every cell updates in the same edge, so an insert or delete shifts the
// whole list at once; the read path is a select across all cells.
// Reset is synchronous; busy is high in the cycle after reset is applied.
// The receiver cannot stall; results are never held.
`default_nettype none

module indexed_list_buffer_core
  import ilb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > 7) ? LW : 7;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [LW-1:0]      length;
  logic [LW-1:0]      length_next;
  logic [CW-1:0]      pos_ext;
  logic [CW-1:0]      len_ext;
  logic [CW-1:0]      cell_pos;
  logic               accept;
  logic               full;
  cell_ctl_t          ctl;
  logic [1:0]         status_c;
  logic signed [31:0] rd_c;
  logic signed [31:0] rd_sel;
  rsp_t               rsp_next;

  logic signed [31:0] cell_data [CAPACITY];
  logic signed [31:0] cell_tap  [CAPACITY];

  assign accept  = start & ~busy;
  assign pos_ext = CW'(req.position);
  assign len_ext = CW'(length);
  assign full    = (len_ext >= CAP_C);

  // Request decode
  always_comb begin
    ctl.op      = CELL_HOLD;
    ctl.value   = req.value;
    cell_pos    = pos_ext;
    status_c    = ST_DONE;
    rd_c        = '0;
    length_next = length;
    unique case (req.req_type)
      REQ_READ: begin
        if (pos_ext < len_ext) begin
          rd_c = rd_sel;
        end else begin
          rd_c     = READ_MISS;
          status_c = ST_RANGE;
        end
      end
      REQ_INS_HEAD: begin
        cell_pos = '0;
        if (full) begin
          status_c = ST_FULL;
        end else begin
          ctl.op      = CELL_INS;
          length_next = length + 1'b1;
        end
      end
      REQ_INS_TAIL: begin
        cell_pos = len_ext;
        if (full) begin
          status_c = ST_FULL;
        end else begin
          ctl.op      = CELL_INS;
          length_next = length + 1'b1;
        end
      end
      REQ_INS_POS: begin
        if (pos_ext > len_ext) begin
          status_c = ST_RANGE;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          ctl.op      = CELL_INS;
          length_next = length + 1'b1;
        end
      end
      REQ_DEL_POS: begin
        if (pos_ext >= len_ext) begin
          status_c = ST_RANGE;
        end else begin
          ctl.op      = CELL_DEL;
          length_next = length - 1'b1;
        end
      end
      default: status_c = ST_RANGE;
    endcase
    if (!accept) begin
      ctl.op = CELL_HOLD;
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_d;
    logic signed [31:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_p
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_n
      assign next_d = cell_data[i+1];
    end
    ilb_cell #(
      .INDEX (i),
      .PW    (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cell_pos),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  // Read select: only the addressed cell drives a nonzero tap
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_tap[i];
    end
  end

  // Result word
  always_comb begin
    rsp_next.read_value  = rd_c;
    rsp_next.status      = status_c;
    rsp_next.list_length = 7'(CW'(length_next));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
      busy   <= 1'b1;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        length <= length_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### design/ilb_cell.sv
// One list cell: holds the entry at a fixed list position and moves it to
// or takes it from its neighbors on insert and delete. Uses ilb_pkg.
`default_nettype none

module ilb_cell
  import ilb_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 7
) (
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic [PW-1:0]      pos,
  input  wire logic signed [31:0] prev_data,
  input  wire logic signed [31:0] next_data,
  output logic signed [31:0]      data,
  output logic signed [31:0]      tap
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic signed [31:0] data_next;

  // Shift up above an insert point, down from a delete point
  always_comb begin
    data_next = data;
    unique case (ctl.op)
      CELL_INS: begin
        if (IDX > pos) begin
          data_next = prev_data;
        end else if (IDX == pos) begin
          data_next = ctl.value;
        end
      end
      CELL_DEL: begin
        if (IDX >= pos) begin
          data_next = next_data;
        end
      end
      default: data_next = data;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Read tap: entry when addressed, zero otherwise
  assign tap = (IDX == pos) ? data : '0;

endmodule

`default_nettype wire

### design/ilb_chk.sv
// Port-level checker for indexed_list_buffer_core, attached by bind.
// Uses ilb_pkg.
`default_nettype none

module ilb_chk
  import ilb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t req,
  input wire logic done,
  input wire rsp_t rsp
);

  // Every transfer gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted request produced no result");

  // No result without a transfer
  a_no_extra: assert property (@(posedge clk)
    !(start && !busy) |=> !done)
    else $error("result without request");

  // Missed read returns all ones
  a_read_miss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_READ) ##1
      (done && rsp.status == ST_RANGE) |-> rsp.read_value == READ_MISS)
    else $error("missed read did not return -1");

  // Non-read requests return zero data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type != REQ_READ) |=> rsp.read_value == '0)
    else $error("non-read request returned data");

  // Reported length never exceeds the capacity
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.list_length <= CAPACITY)
    else $error("list length above capacity");

endmodule

bind indexed_list_buffer_core ilb_chk #(
  .CAPACITY (CAPACITY)
) u_ilb_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

### tb/ilb_checker.sv
// Scoreboard for the indexed list buffer: watches request and result transfers,
// keeps a shadow copy of the list and compares every result field by field.
// Depends on ilb_pkg.
module ilb_checker
  import ilb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t req,
  input  wire logic done,
  input  wire rsp_t rsp,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow list and its occupancy
  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_len;
  rsp_t               expected_rsp_q [$];

  // Applies one request to the shadow list and returns the result it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   ins_at;
    res             = '0;
    res.status      = ST_DONE;
    ins_at          = -1;
    case (r.req_type)
      REQ_READ: begin
        if (r.position < shadow_len) begin
          res.read_value = shadow_list[r.position];
        end else begin
          res.read_value = READ_MISS;
          res.status     = ST_RANGE;
        end
      end
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (shadow_len >= CAPACITY) res.status = ST_FULL;
        else ins_at = (r.req_type == REQ_INS_HEAD) ? 0 : shadow_len;
      end
      REQ_INS_POS: begin
        // range check takes priority over the full check
        if (r.position > shadow_len) res.status = ST_RANGE;
        else if (shadow_len >= CAPACITY) res.status = ST_FULL;
        else ins_at = r.position;
      end
      REQ_DEL_POS: begin
        if (r.position >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = r.position; i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      default: res.status = ST_RANGE;
    endcase
    // shift the tail up and drop the new value in
    if (ins_at >= 0) begin
      for (int i = shadow_len; i > ins_at; i--)
        shadow_list[i] = shadow_list[i - 1];
      shadow_list[ins_at] = r.value;
      shadow_len++;
    end
    res.list_length = 7'(shadow_len);
    return res;
  endfunction

  // Result check first: a result never belongs to the transfer at the same edge
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_len = 0;
      expected_rsp_q.delete();
    end else begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: read_value %0d status %0d length %0d",
                   $time, $signed(rsp.read_value), rsp.status, rsp.list_length);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %0d actual %0d",
                     $time, $signed(want.read_value), $signed(rsp.read_value));
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.list_length !== want.list_length) begin
            $display("%0t: list_length mismatch: expected %0d actual %0d",
                     $time, want.list_length, rsp.list_length);
            errors++;
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(apply_request(req));
    end
    pending = expected_rsp_q.size();
  end

endmodule

### tb/tb_top.sv
// Top of the indexed list buffer testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on ilb_pkg, ilb_checker and indexed_list_buffer_core.
module tb_top
  import ilb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY       = 64;
  localparam int          RANDOM_ITEMS   = 1000;
  localparam int          QUIET_TAIL     = 150;
  localparam int          WATCHDOG_LIMIT = 1000;

  // Request codes the block does not define
  localparam logic [2:0] REQ_RSVD_A = 3'd5;
  localparam logic [2:0] REQ_RSVD_B = 3'd6;
  localparam logic [2:0] REQ_RSVD_C = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   stall_cycles = 0;
  int   fill_est     = 0;

  indexed_list_buffer_core #(.CAPACITY(CAPACITY)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  ilb_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .rsp    (rsp),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t mk(logic [2:0] kind, int pos, logic [31:0] val);
    req_t r;
    r.req_type = kind;
    r.position = 7'(pos);
    r.value    = val;
    return r;
  endfunction

  // Occupancy after a request, used only to aim positions
  function automatic int next_fill(req_t r, int n);
    case (r.req_type)
      REQ_INS_HEAD, REQ_INS_TAIL: return (n < CAPACITY) ? n + 1 : n;
      REQ_INS_POS:                return (r.position <= n && n < CAPACITY) ? n + 1 : n;
      REQ_DEL_POS:                return (r.position < n) ? n - 1 : n;
      default:                    return n;
    endcase
  endfunction

  // Mostly legal positions, biased toward growing or shrinking the list
  function automatic req_t random_request(bit growing, int n);
    req_t        r;
    int          pick;
    logic [31:0] val;
    logic [2:0]  rsvd [3];
    rsvd = '{REQ_RSVD_A, REQ_RSVD_B, REQ_RSVD_C};
    case ($urandom_range(0, 7))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      default: val = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r = mk(rsvd[$urandom_range(0, 2)], $urandom_range(0, 127), val);
    end else if (pick < 10) begin
      // anything goes, mostly out of range
      r = mk(3'($urandom_range(REQ_READ, REQ_DEL_POS)), $urandom_range(0, 127), val);
    end else if (pick < 30) begin
      r = mk(REQ_READ, (n > 0) ? $urandom_range(0, n - 1) : 0, val);
    end else if ((pick < 75) == growing) begin
      case ($urandom_range(0, 2))
        0:       r = mk(REQ_INS_HEAD, $urandom_range(0, 127), val);
        1:       r = mk(REQ_INS_TAIL, $urandom_range(0, 127), val);
        default: r = mk(REQ_INS_POS, $urandom_range(0, n), val);
      endcase
    end else begin
      r = mk(REQ_DEL_POS, (n > 0) ? $urandom_range(0, n - 1) : 0, val);
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(input req_t r);
    start <= 1'b1;
    req   <= r;
    while (busy) @(negedge clk);
    @(negedge clk);
    fill_est = next_fill(r, fill_est);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    bit growing;
    bit gaps_on;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, range errors, value extremes, reserved codes
    issue(mk(REQ_READ, 0, 32'h0));
    issue(mk(REQ_READ, 127, 32'h0));
    issue(mk(REQ_DEL_POS, 0, 32'h0));
    issue(mk(REQ_INS_POS, 1, 32'h1111_1111));
    issue(mk(REQ_INS_POS, 0, 32'h7fff_ffff));
    issue(mk(REQ_INS_HEAD, 0, 32'h8000_0000));
    issue(mk(REQ_INS_TAIL, 127, 32'hffff_ffff));
    issue(mk(REQ_INS_TAIL, 0, 32'h0));
    issue(mk(REQ_INS_POS, 4, 32'h1234_5678));
    issue(mk(REQ_INS_POS, 2, 32'ha5a5_a5a5));
    issue(mk(REQ_READ, 0, 32'h0));
    issue(mk(REQ_READ, 5, 32'hffff_ffff));
    issue(mk(REQ_READ, 6, 32'h0));
    issue(mk(REQ_READ, 127, 32'h0));
    issue(mk(REQ_RSVD_A, 127, 32'hffff_ffff));
    issue(mk(REQ_RSVD_B, 0, 32'h0));
    issue(mk(REQ_RSVD_C, 64, 32'h5a5a_5a5a));
    issue(mk(REQ_INS_POS, 127, 32'h0));
    issue(mk(REQ_DEL_POS, 6, 32'h0));
    issue(mk(REQ_DEL_POS, 5, 32'h0));
    issue(mk(REQ_DEL_POS, 0, 32'h0));
    issue(mk(REQ_DEL_POS, 127, 32'h0));
    issue(mk(REQ_READ, 1, 32'h0));

    // Random: swing the list between empty and full, gaps in some stretches
    growing = 1'b1;
    gaps_on = 1'b0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (gaps_on && k < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
        pause($urandom_range(1, 18));
      // linger a little at full and at empty before turning around
      if (growing && fill_est >= CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && fill_est == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      issue(random_request(growing, fill_est));
    end
    start <= 1'b0;

    // Drain the last result, then idle to catch anything stray
    wait (pending == 0);
    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
